// ===== hw/rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    // Pipeline depth: hue decode, multiply, partial products, scaling, output.
    localparam int NUM_STAGES = 5;

    localparam logic [12:0] ONE_FX    = 13'd4096;
    localparam logic [11:0] SEG_WIDTH = 12'd600;

    // floor(y / 5) for y below 43690 is (y * 26215) >> 17; the factor 17 of
    // 255 / 600 = 17 / 40 is folded in, so tri * TRI_RECIP >> 17 = floor(tri * 17 / 5).
    localparam logic [18:0] TRI_RECIP = 19'd445655;
    localparam int          TRI_SHIFT = 17;

    // floor(x / 5) for x below 2^27 is (x * FIFTH_RECIP) >> 29.
    localparam logic [26:0] FIFTH_RECIP = 27'd107374183;
    localparam int          FIFTH_SHIFT = 29;

    localparam logic [7:0] CH_MAX = 8'd255;

    // Sixty-degree hue sectors.
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } flow_ctl_t;

    // Hand-off from the front half to the back half of the pipeline.
    typedef struct packed {
        logic [12:0] val;
        logic [24:0] vs;
        logic [11:0] t1;
        logic [9:0]  tri_w;
        sector_t     sector;
        logic [7:0]  chan_full;
        logic [7:0]  alpha;
    } mid_t;

    function automatic logic [12:0] clamp_one(input logic [12:0] v);
        logic [12:0] r;
        r = (v > ONE_FX) ? ONE_FX : v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/hsv2rgb_flow.sv =====
module hsv2rgb_flow (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hsv2rgb_pkg::flow_ctl_t ctl
);
    import hsv2rgb_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load  = ready;
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== hw/rtl/hsv2rgb_front.sv =====
module hsv2rgb_front (
    input  logic                   clk,
    input  hsv2rgb_pkg::flow_ctl_t ctl,
    input  logic [11:0]            hue,
    input  logic [12:0]            saturation,
    input  logic [12:0]            brightness,
    input  logic [12:0]            opacity,
    output hsv2rgb_pkg::mid_t      mid
);
    import hsv2rgb_pkg::*;

    // Stage 0: clamp and hue decode.
    logic [12:0] sat_reg, val_reg, opa_reg;
    logic [9:0]  tri_reg, tri_next;
    sector_t     sector_reg, sector_next;
    logic [11:0] hm_wide;
    logic [10:0] hm;
    logic [10:0] hue_dist_wide;
    logic [9:0]  hue_dist;

    always_comb
    begin
        if (hue < 12'd600)
        begin
            sector_next = SECT_RED_YELLOW;
        end
        else if (hue < 12'd1200)
        begin
            sector_next = SECT_YELLOW_GREEN;
        end
        else if (hue < 12'd1800)
        begin
            sector_next = SECT_GREEN_CYAN;
        end
        else if (hue < 12'd2400)
        begin
            sector_next = SECT_CYAN_BLUE;
        end
        else if (hue < 12'd3000)
        begin
            sector_next = SECT_BLUE_MAGENTA;
        end
        else
        begin
            sector_next = SECT_MAGENTA_RED;
        end

        if (hue >= 12'd3600)
        begin
            hm_wide = hue - 12'd3600;
        end
        else if (hue >= 12'd2400)
        begin
            hm_wide = hue - 12'd2400;
        end
        else if (hue >= 12'd1200)
        begin
            hm_wide = hue - 12'd1200;
        end
        else
        begin
            hm_wide = hue;
        end
        hm = hm_wide[10:0];

        if (hm >= SEG_WIDTH[10:0])
        begin
            hue_dist_wide = hm - SEG_WIDTH[10:0];
        end
        else
        begin
            hue_dist_wide = SEG_WIDTH[10:0] - hm;
        end
        hue_dist = hue_dist_wide[9:0];
        tri_next = SEG_WIDTH[9:0] - hue_dist;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            sat_reg    <= clamp_one(saturation);
            val_reg    <= clamp_one(brightness);
            opa_reg    <= clamp_one(opacity);
            tri_reg    <= tri_next;
            sector_reg <= sector_next;
        end
    end

    // Stage 1: chroma product and the scaled triangle term.
    logic [25:0] vs_full;
    logic [28:0] tri_prod;
    logic [20:0] val_scaled;
    logic [20:0] opa_scaled;
    mid_t        mid_reg, mid_next;

    assign vs_full    = val_reg * sat_reg;
    assign tri_prod   = tri_reg * TRI_RECIP;
    assign val_scaled = val_reg * CH_MAX;
    assign opa_scaled = opa_reg * CH_MAX;

    always_comb
    begin
        mid_next.val       = val_reg;
        mid_next.vs        = vs_full[24:0];
        mid_next.t1        = tri_prod[28:TRI_SHIFT];
        mid_next.tri_w     = tri_reg;
        mid_next.sector    = sector_reg;
        mid_next.chan_full = val_scaled[19:12];
        mid_next.alpha     = opa_scaled[19:12];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ===== hw/rtl/hsv2rgb_back.sv =====
module hsv2rgb_back (
    input  logic                   clk,
    input  hsv2rgb_pkg::flow_ctl_t ctl,
    input  hsv2rgb_pkg::mid_t      mid,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    output logic [7:0]             alpha_out
);
    import hsv2rgb_pkg::*;

    // Stage 2: offset term, remainder of the triangle split, main product.
    logic [24:0] d2_reg, d2_next;
    logic [24:0] vs2_reg;
    logic [35:0] pv2_reg;
    logic [2:0]  t2_reg;
    sector_t     sector2_reg;
    logic [7:0]  full2_reg, alpha2_reg;
    logic [24:0] val_sh;
    logic [13:0] tri17;
    logic [13:0] five_t1;
    logic [13:0] t2_wide;
    logic [36:0] pv_full;

    assign val_sh  = {mid.val[12:0], 12'b0};
    assign d2_next = val_sh - mid.vs;
    assign tri17   = {4'b0, mid.tri_w} * 14'd17;
    assign five_t1 = {2'b0, mid.t1} * 14'd5;
    assign t2_wide = tri17 - five_t1;
    assign pv_full = mid.vs * mid.t1;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            d2_reg      <= d2_next;
            vs2_reg     <= mid.vs;
            pv2_reg     <= pv_full[35:0];
            t2_reg      <= t2_wide[2:0];
            sector2_reg <= mid.sector;
            full2_reg   <= mid.chan_full;
            alpha2_reg  <= mid.alpha;
        end
    end

    // Stage 3: fractional fifth of the leftover product, zero channel.
    logic [26:0] vt;
    logic [53:0] q_full;
    logic [32:0] d_scaled;
    logic [23:0] q3_reg;
    logic [24:0] d3_reg;
    logic [35:0] pv3_reg;
    sector_t     sector3_reg;
    logic [7:0]  zero3_reg, full3_reg, alpha3_reg;

    always_comb
    begin
        case (t2_reg)
            3'd1:    vt = {2'b0, vs2_reg};
            3'd2:    vt = {1'b0, vs2_reg, 1'b0};
            3'd3:    vt = {1'b0, vs2_reg, 1'b0} + {2'b0, vs2_reg};
            3'd4:    vt = {vs2_reg, 2'b0};
            default: vt = '0;
        endcase
    end

    assign q_full   = vt * FIFTH_RECIP;
    assign d_scaled = d2_reg * CH_MAX;

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            q3_reg      <= q_full[52:FIFTH_SHIFT];
            d3_reg      <= d2_reg;
            pv3_reg     <= pv2_reg;
            sector3_reg <= sector2_reg;
            zero3_reg   <= d_scaled[31:24];
            full3_reg   <= full2_reg;
            alpha3_reg  <= alpha2_reg;
        end
    end

    // Stage 4: secondary channel sum and sector routing into the output beat.
    logic [35:0] sec_sum;
    logic [7:0]  sec_chan;
    logic [7:0]  red_next, green_next, blue_next;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;

    assign sec_sum  = ({11'b0, d3_reg} << 11) - ({11'b0, d3_reg} << 3)
                    + pv3_reg + {12'b0, q3_reg};
    assign sec_chan = sec_sum[34:27];

    always_comb
    begin
        case (sector3_reg)
            SECT_RED_YELLOW:
            begin
                red_next = full3_reg; green_next = sec_chan;  blue_next = zero3_reg;
            end
            SECT_YELLOW_GREEN:
            begin
                red_next = sec_chan;  green_next = full3_reg; blue_next = zero3_reg;
            end
            SECT_GREEN_CYAN:
            begin
                red_next = zero3_reg; green_next = full3_reg; blue_next = sec_chan;
            end
            SECT_CYAN_BLUE:
            begin
                red_next = zero3_reg; green_next = sec_chan;  blue_next = full3_reg;
            end
            SECT_BLUE_MAGENTA:
            begin
                red_next = sec_chan;  green_next = zero3_reg; blue_next = full3_reg;
            end
            default:
            begin
                red_next = full3_reg; green_next = zero3_reg; blue_next = sec_chan;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha3_reg;
        end
    end

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_unit.sv =====
// HSV to RGBA pixel converter.
// The input channel carries one HSV pixel per beat: hue in tenths of a degree,
// and saturation, brightness and opacity in fixed point where 4096 is 1.0.
// Values above 4096 are clamped to 4096, and hues from 3600 up fall into the
// last sector. The output channel carries one 8-bit RGBA pixel per beat.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The conversion is a five-stage pipeline: a pixel accepted into
// the first stage moves through the stage registers in turn to the output
// register and leaves it when out_stall is low. While the output does not stall,
// one pixel can enter every cycle, so the sustained rate is one pixel per clock.
// The deepest stage holds the 27 by 27 bit reciprocal multiply that splits off
// the last fifth of the secondary term; the 13 by 13 bit chroma multiply and
// the 25 by 12 bit secondary product sit in the two stages before it.
// Reset empties the pipeline; no pixel is in flight afterwards and the block
// is ready to accept at once. When the receiver stalls, the output beat holds
// steady and the stages behind it keep filling any empty slots, so the input
// stalls only once every stage holds a pixel.
module hsv_to_rgb_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] hue,
    input  logic [12:0] saturation,
    input  logic [12:0] brightness,
    input  logic [12:0] opacity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha_out
);
    import hsv2rgb_pkg::*;

    flow_ctl_t ctl;
    mid_t      mid;

    // Valid bits and stage load enables for the whole pipeline.
    hsv2rgb_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Clamping, hue decode, chroma product and the triangle term.
    hsv2rgb_front u_front (
        .clk        (clk),
        .ctl        (ctl),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .opacity    (opacity),
        .mid        (mid)
    );

    // Exact channel scaling and sector routing into the output register.
    hsv2rgb_back u_back (
        .clk       (clk),
        .ctl       (ctl),
        .mid       (mid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_out (alpha_out)
    );

endmodule
